FILE: rtl/core/wbps_pkg.sv
// Package for the wildcard byte pattern search block.
// Holds shared types, register index codes and parameter defaults.
// Used by wbps_cell, wildcard_byte_pattern_search and the testbench; depends on nothing.
package wbps_pkg;

	localparam int PATTERN_MAX_DEF   = 16;
	localparam int POSITION_BITS_DEF = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_REG_W  = 5;
	localparam int START_W    = 32;
	localparam int POS_OUT_W  = 32;

	typedef logic [7:0]   byte_t;
	typedef logic [255:0] wild_set_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WILD_0   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WILD_1   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WILD_2   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WILD_3   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd7;

endpackage

FILE: rtl/core/wbps_cell.sv
// One cell of the match chain: compares the broadcast text byte with its own
// pattern byte and extends the partial match handed over by its neighbor.
// Depends on wbps_pkg.
module wbps_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               prev_match,
	input  wbps_pkg::byte_t    text_byte,
	input  wbps_pkg::byte_t    pattern_byte,
	input  wbps_pkg::wild_set_t wild_set,
	output logic               match
);
	import wbps_pkg::*;

	logic byte_ok;
	logic match_q;

	// A wildcard pattern byte accepts any text byte.
	assign byte_ok = wild_set[pattern_byte] || (text_byte == pattern_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (en) begin
			match_q <= prev_match && byte_ok;
		end
	end

	assign match = match_q;

endmodule

FILE: rtl/core/wildcard_byte_pattern_search.sv
// Top level of the wildcard byte pattern search block.
// Instantiates a chain of wbps_cell match cells; depends on wbps_pkg.
//
// This block scans a text that arrives one byte per beat on the slave stream
// (tlast marks the final byte) and reports the first index at or after the
// configured start offset where the configured pattern of up to sixteen bytes
// matches. A pattern byte whose value is a member of the 256-entry wildcard set
// matches any text byte. Exactly one result beat leaves per text: tuser high with
// the position of the first matching byte as soon as the last byte of the match
// has arrived, or tuser low and a zero position with the final byte of the text.
// An empty pattern reports the start offset once the text reaches it. A byte is
// taken every cycle while no result beat is held back by the receiver; a held
// result lets at most one more byte in and then stalls the text stream until the
// result is taken. The beat that completes a result is registered in the cell
// chain and stage one, and the result then in the output register. The chain
// keeps one partial-match flag per pattern position, so no window of text bytes
// is stored. Configuration may be written only while no text is in flight.
module wildcard_byte_pattern_search #(
	parameter int PATTERN_MAX   = wbps_pkg::PATTERN_MAX_DEF,
	parameter int POSITION_BITS = wbps_pkg::POSITION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_we,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Text stream.
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // text_byte
	input  logic                               s_axis_tlast,  // end_of_text
	// Result stream.
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [wbps_pkg::POS_OUT_W-1:0]     m_axis_tdata,  // match_position
	output logic                               m_axis_tuser   // found
);
	import wbps_pkg::*;

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	// Compare width that holds both a position plus one and the start offset.
	localparam int CW = (POSITION_BITS + 1 > START_W + 1) ? POSITION_BITS + 1 : START_W + 1;

	// Configuration registers.
	logic [CFG_DATA_W-1:0] pat_lo_q;
	logic [CFG_DATA_W-1:0] pat_hi_q;
	logic [LEN_REG_W-1:0]  len_q;
	wild_set_t             wset_q;
	logic [START_W-1:0]    start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			len_q    <= '0;
			wset_q   <= '0;
			start_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAT_LOW:  pat_lo_q <= cfg_data;
				REG_PAT_HIGH: pat_hi_q <= cfg_data;
				REG_PAT_LEN:  len_q <= cfg_data[LEN_REG_W-1:0];
				REG_WILD_0:   wset_q[63:0] <= cfg_data;
				REG_WILD_1:   wset_q[127:64] <= cfg_data;
				REG_WILD_2:   wset_q[191:128] <= cfg_data;
				REG_WILD_3:   wset_q[255:192] <= cfg_data;
				REG_START:    start_q <= cfg_data[START_W-1:0];
				default: ;
			endcase
		end
	end

	// Pattern lengths beyond the chain length saturate to it.
	logic [LEN_W-1:0] len_eff;
	assign len_eff = (32'(len_q) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX) : LEN_W'(len_q);

	// Handshake and stage control.
	logic valid_s1;
	logic adv;
	logic accept;
	logic out_valid_q;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Match chain. Flag j is high when pattern bytes 0..j match the text ending
	// at the most recent accepted byte. Bytes of an earlier text can only reach
	// a flag that is not consulted, because the window check below requires the
	// whole window to lie inside the current text.
	logic [PATTERN_MAX-1:0] chain;

	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
		byte_t pbyte;
		logic  prev;

		if (j < 8) begin : g_lo
			assign pbyte = pat_lo_q[8*j +: 8];
		end else if (j < 16) begin : g_hi
			assign pbyte = pat_hi_q[8*(j-8) +: 8];
		end else begin : g_zero
			assign pbyte = '0;
		end

		if (j == 0) begin : g_first
			assign prev = 1'b1;
		end else begin : g_next
			assign prev = chain[j-1];
		end

		wbps_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.en           (accept),
			.prev_match   (prev),
			.text_byte    (s_axis_tdata),
			.pattern_byte (pbyte),
			.wild_set     (wset_q),
			.match        (chain[j])
		);
	end

	// Byte index within the text; it saturates at all ones, where no match may end.
	logic [POSITION_BITS-1:0] idx_q;
	logic                     in_range;
	logic [CW-1:0]            ip1;
	logic [CW-1:0]            start_pos;
	logic                     cand;
	logic                     emp;

	assign in_range = (idx_q != '1);
	assign ip1      = CW'(idx_q) + CW'(1);
	assign start_pos = ip1 - CW'(len_eff);
	assign cand     = in_range && (len_eff != '0) && (ip1 >= CW'(len_eff)) &&
	                  (start_pos >= CW'(start_q));
	assign emp      = in_range && (CW'(idx_q) == CW'(start_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				idx_q <= '0;
			end else if (in_range) begin
				idx_q <= idx_q + POSITION_BITS'(1);
			end
		end
	end

	// Stage one holds what the beat just accepted needs for its decision; the
	// chain flags themselves sit in the cells.
	logic                   last_s1;
	logic                   cand_s1;
	logic                   emp_s1;
	logic                   lenz_s1;
	logic [PATTERN_MAX-1:0] sel_s1;
	logic [CW-1:0]          pos_s1;
	logic [PATTERN_MAX-1:0] sel;

	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_sel
		assign sel[j] = (32'(len_eff) == j + 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= s_axis_tlast;
			cand_s1 <= cand;
			emp_s1  <= emp;
			lenz_s1 <= (len_eff == '0);
			sel_s1  <= sel;
			pos_s1  <= (len_eff == '0) ? CW'(idx_q) : start_pos;
		end
	end

	// Stage two: final decision and the once-per-text bookkeeping.
	logic          given_q;
	logic          hit;
	logic          emit;
	logic          found_q;
	logic [CW-1:0] pos_q;

	assign hit  = !given_q && (lenz_s1 ? emp_s1 : (cand_s1 && |(chain & sel_s1)));
	assign emit = hit || (last_s1 && !given_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			given_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && emit;
			if (valid_s1) begin
				given_q <= last_s1 ? 1'b0 : (given_q || hit);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			found_q <= hit;
			pos_q   <= hit ? pos_s1 : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = found_q;
	assign m_axis_tdata  = pos_q[POS_OUT_W-1:0];

	// A reported match never begins before the start offset.
	a_pos_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> pos_q >= CW'(start_q))
		else $error("match reported before start offset");

	// A not-found result carries a zero position.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> pos_q == '0)
		else $error("not-found result with nonzero position");

	// A beat held in stage one is never overwritten while the output stalls.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |-> !accept)
		else $error("stage one overwritten during stall");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the wildcard byte pattern search block.
// Drives text beats and register writes, predicts every result beat and checks it.
// Depends on wbps_pkg and wildcard_byte_pattern_search.
`timescale 1ns / 1ps

module testbench;
	import wbps_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	// Idle time after draining that lets the block's pipeline run dry with margin.
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_BEATS  = 1800;
	localparam int PRINT_LIMIT   = 100;

	typedef struct packed {
		byte_t value;
		logic  last;
	} text_beat_t;

	typedef struct packed {
		logic                 found;
		logic [POS_OUT_W-1:0] position;
	} search_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;  // text_byte
	logic                  s_axis_tlast = 1'b0;  // end_of_text
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [POS_OUT_W-1:0]  m_axis_tdata;  // match_position
	logic                  m_axis_tuser;  // found

	// Our own copy of the block's registers and scan state.
	logic [127:0]          pattern_bits = '0;
	wild_set_t             wild_bits = '0;
	logic [LEN_REG_W-1:0]  pattern_len = '0;
	logic [START_W-1:0]    start_ofs = '0;
	byte_t                 tail_bytes [16];
	logic [31:0]           text_index = '0;
	logic                  text_reported = 1'b0;

	text_beat_t            text_queue [$];
	search_result_t        search_results_due [$];
	text_beat_t            beat_out;
	search_result_t        predicted;
	search_result_t        want;
	bit                    hold_sender = 1'b0;
	int unsigned           gap_left = 0;
	int unsigned           burst_left = 0;
	logic [31:0]           ready_pattern = '0;
	logic [5:0]            pattern_age = '0;
	int unsigned           mismatch_count = 0;
	int unsigned           cycle_count = 0;

	wildcard_byte_pattern_search uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		for (int k = 0; k < 16; k++) tail_bytes[k] = '0;
	end

	// Advances the scan by one text byte. Returns 1 when the byte produces a
	// result, which is then left in res.
	function automatic bit scan_byte(input byte_t b, input logic last,
			output search_result_t res);
		int unsigned len;
		bit          in_range;
		bit          hit;
		bit          given;
		byte_t       p;
		logic [31:0] begin_at;

		len = (pattern_len > 16) ? 16 : pattern_len;
		in_range = (text_index != 32'hFFFF_FFFF);
		hit = 1'b0;
		given = 1'b0;
		begin_at = '0;
		res = '0;

		for (int k = 15; k > 0; k--) tail_bytes[k] = tail_bytes[k-1];
		tail_bytes[0] = b;

		if (!text_reported && in_range) begin
			if (len == 0) begin
				// An empty pattern hits exactly on the byte at the start offset.
				hit = (text_index == start_ofs);
				begin_at = text_index;
			end else if (longint'(text_index) + 1 >= len) begin
				begin_at = text_index + 1 - len;
				hit = (begin_at >= start_ofs);
				for (int j = 0; j < len; j++) begin
					p = pattern_bits[8*j +: 8];
					if (!wild_bits[p] && tail_bytes[len-1-j] != p) hit = 1'b0;
				end
			end
		end

		if (hit) begin
			res.found = 1'b1;
			res.position = begin_at;
			text_reported = 1'b1;
			given = 1'b1;
		end

		if (last) begin
			// The final byte of a text without a hit reports the miss.
			if (!text_reported) begin
				res = '0;
				given = 1'b1;
			end
			text_index = '0;
			text_reported = 1'b0;
		end else if (in_range) begin
			text_index = text_index + 1;
		end
		return given;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// Writes one register and mirrors it in the predictor's copy. Only called
	// while no text is in flight.
	task automatic write_search_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_PAT_LOW:  pattern_bits[63:0] = value;
			REG_PAT_HIGH: pattern_bits[127:64] = value;
			REG_PAT_LEN:  pattern_len = value[LEN_REG_W-1:0];
			REG_WILD_0:   wild_bits[63:0] = value;
			REG_WILD_1:   wild_bits[127:64] = value;
			REG_WILD_2:   wild_bits[191:128] = value;
			REG_WILD_3:   wild_bits[255:192] = value;
			REG_START:    start_ofs = value[START_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_beat(input byte_t value, input logic last);
		text_beat_t beat;
		beat.value = value;
		beat.last = last;
		text_queue.insert(text_queue.size(), beat);
	endtask

	// Waits until every queued beat is taken and every result is back, then
	// lets the pipeline run dry. Polled on the falling edge so that all
	// updates of the rising edge have settled.
	task automatic drain_and_settle();
		@(negedge clk);
		while (text_queue.size() != 0 || s_axis_tvalid || search_results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sender: bursts of random length separated by random gaps. A beat that
	// is offered stays on the bus unchanged until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			gap_left <= 0;
			burst_left <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left != 0) begin
				s_axis_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (hold_sender || text_queue.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				beat_out = text_queue.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= beat_out.value;
				s_axis_tlast <= beat_out.last;
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(1, 32);
					gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
				end
			end
		end
	end

	// Receiver: ready follows a rotating 32-bit pattern that is reloaded whenever
	// the 6-bit pattern_age counter wraps; some reloads are all ones for stall-free stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_pattern <= '0;
			pattern_age <= '0;
		end else begin
			m_axis_tready <= ready_pattern[0];
			pattern_age <= pattern_age + 1;
			if (pattern_age == 0) begin
				case ($urandom_range(0, 3))
					0:       ready_pattern <= '1;
					1:       ready_pattern <= $urandom | $urandom;
					2:       ready_pattern <= $urandom & $urandom;
					default: ready_pattern <= $urandom;
				endcase
			end else begin
				ready_pattern <= {ready_pattern[0], ready_pattern[31:1]};
			end
		end
	end

	// Monitor: predicts on every accepted text beat, checks every result beat
	// against the oldest outstanding prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (scan_byte(s_axis_tdata, s_axis_tlast, predicted))
					search_results_due.insert(search_results_due.size(), predicted);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (search_results_due.size() == 0) begin
					report_mismatch($sformatf("result beat with none due: found=%0b pos=%0d",
						m_axis_tuser, m_axis_tdata));
				end else begin
					want = search_results_due.pop_front();
					if (m_axis_tuser !== want.found)
						report_mismatch($sformatf("found flag %0b, predicted %0b",
							m_axis_tuser, want.found));
					if (m_axis_tdata !== want.position)
						report_mismatch($sformatf("match position %0d, predicted %0d",
							m_axis_tdata, want.position));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		logic [127:0]         pat;
		wild_set_t            wild;
		logic [LEN_REG_W-1:0] len_code;
		logic [START_W-1:0]   start;
		byte_t                alphabet [4];
		byte_t                tb;
		int unsigned          eff_len;
		int unsigned          phase;
		int unsigned          random_beats;
		int unsigned          phase_beats;
		int unsigned          phase_target;
		int unsigned          text_len;
		int unsigned          plant_at;
		bit                   plant;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at their reset values: an empty pattern with a zero start
		// offset hits on the very first byte.
		add_beat(8'h00, 1'b1);
		drain_and_settle();

		// Empty pattern with a start offset of three: the first text ends
		// before the offset, the second one reaches it on its last byte.
		write_search_reg(REG_START, 64'd3);
		add_beat(8'h01, 1'b0);
		add_beat(8'h02, 1'b1);
		add_beat(8'h01, 1'b0);
		add_beat(8'h02, 1'b0);
		add_beat(8'h03, 1'b0);
		add_beat(8'h04, 1'b1);
		drain_and_settle();

		// Exact two-byte search for 00 FF. The text matches twice; only the
		// first hit is reported and the final byte gives nothing more.
		write_search_reg(REG_PAT_LOW, 64'h0000_0000_0000_FF00);
		write_search_reg(REG_PAT_LEN, 64'd2);
		write_search_reg(REG_START, 64'd0);
		add_beat(8'hFF, 1'b0);
		add_beat(8'h00, 1'b0);
		add_beat(8'hFF, 1'b0);
		add_beat(8'h00, 1'b0);
		add_beat(8'hFF, 1'b1);
		drain_and_settle();

		// Pattern "*" then 80 with '*' in the wildcard set. With the start
		// offset at its maximum the text can never reach it.
		write_search_reg(REG_PAT_LOW, 64'h0000_0000_0000_802A);
		write_search_reg(REG_WILD_0, 64'h1 << 8'h2A);
		write_search_reg(REG_START, 64'hFFFF_FFFF);
		add_beat(8'h80, 1'b0);
		add_beat(8'h80, 1'b1);
		drain_and_settle();
		write_search_reg(REG_START, 64'd0);
		add_beat(8'h55, 1'b0);
		add_beat(8'h80, 1'b1);
		drain_and_settle();

		// Random phases: fresh registers each time, then texts built mostly
		// from a small alphabet with the pattern planted in most of them.
		phase = 0;
		random_beats = 0;
		while (random_beats < RANDOM_BEATS) begin
			for (int k = 0; k < 4; k++) alphabet[k] = byte_t'($urandom);
			for (int k = 0; k < 16; k++) pat[8*k +: 8] = alphabet[$urandom_range(0, 3)];

			case ($urandom_range(0, 9))
				0:       len_code = '0;
				1:       len_code = 5'd16;
				2:       len_code = $urandom_range(17, 31);
				default: len_code = $urandom_range(1, 6);
			endcase

			wild = '0;
			case ($urandom_range(0, 5))
				2, 3: begin
					for (int k = 0; k < 2; k++) begin
						tb = pat[8*$urandom_range(0, 15) +: 8];
						wild[tb] = 1'b1;
					end
				end
				4: wild = {$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom};
				5: wild = {$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom} &
					{$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom};
				default: ;
			endcase

			case ($urandom_range(0, 7))
				0:       start = '1;
				1:       start = $urandom;
				default: start = $urandom_range(0, 8);
			endcase

			// The first phases pin the registers to their extremes.
			if (phase == 0) begin
				pat = '1;
				wild = '1;
				len_code = '1;
				start = '0;
			end else if (phase == 1) begin
				pat = '0;
				wild = '0;
				len_code = 5'd16;
				start = '0;
			end else if (phase == 2) begin
				start = '1;
			end
			eff_len = (len_code > 16) ? 16 : len_code;

			// Unused upper bits of the narrow registers carry random junk.
			write_search_reg(REG_PAT_LOW, pat[63:0]);
			write_search_reg(REG_PAT_HIGH, pat[127:64]);
			write_search_reg(REG_PAT_LEN, {$urandom, 27'($urandom), len_code});
			write_search_reg(REG_WILD_0, wild[63:0]);
			write_search_reg(REG_WILD_1, wild[127:64]);
			write_search_reg(REG_WILD_2, wild[191:128]);
			write_search_reg(REG_WILD_3, wild[255:192]);
			write_search_reg(REG_START, {$urandom, start});

			phase_beats = 0;
			phase_target = $urandom_range(20, 100);
			while (phase_beats < phase_target) begin
				plant = ($urandom_range(0, 2) != 0);
				text_len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 70)
					: $urandom_range(1, 24);
				if (plant && text_len < eff_len) text_len = eff_len;
				plant_at = plant ? $urandom_range(0, text_len - eff_len) : 0;
				for (int j = 0; j < text_len; j++) begin
					if (plant && j >= plant_at && j < plant_at + eff_len) begin
						tb = pat[8*(j-plant_at) +: 8];
						if (wild[tb]) tb = byte_t'($urandom);
					end else if ($urandom_range(0, 3) == 0) begin
						tb = byte_t'($urandom);
					end else begin
						tb = alphabet[$urandom_range(0, 3)];
					end
					add_beat(tb, j == text_len - 1);
				end
				phase_beats += text_len;
			end

			// Now and then the sender stops in the middle of the stream, quite
			// possibly inside a text, until every due result has come back.
			if (phase % 4 == 2) begin
				@(negedge clk);
				while (text_queue.size() > phase_beats / 2) @(negedge clk);
				hold_sender = 1'b1;
				while (s_axis_tvalid || search_results_due.size() != 0) @(negedge clk);
				hold_sender = 1'b0;
			end

			drain_and_settle();
			random_beats += phase_beats;
			phase++;
		end

		if (search_results_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", search_results_due.size()));
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
